FILE: rtl/core/srld_pkg.sv
// Shared types, constants and codes of the sprite run-length line decoder.
`default_nettype none

package srld_pkg;

    localparam int DIM_BITS = 10;
    localparam int CNT_W = (DIM_BITS > 8) ? DIM_BITS : 8;

    localparam int PADDR_W = 4;
    localparam int ADDR_LSB = 2;
    localparam int REG_IDX_W = 2;

    localparam logic [REG_IDX_W-1:0] REG_SPRITE_WIDTH = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_SPRITE_HEIGHT = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_TRANSPARENT_COLOR = 2'd2;

    localparam logic [7:0] CODE_FILL = 8'hFF;
    localparam logic [7:0] CODE_PIXEL = 8'hFE;
    localparam logic [7:0] CODE_MULTI = 8'hFD;
    localparam logic [7:0] CODE_END = 8'hFC;

    localparam logic [1:0] ST_RUNNING = 2'd0;
    localparam logic [1:0] ST_FINISHED = 2'd1;
    localparam logic [1:0] ST_EARLY_END = 2'd2;
    localparam logic [1:0] ST_BAD_MODE = 2'd3;

    typedef enum logic [5:0] {
        PH_MODE       = 6'b000001,
        PH_DATA       = 6'b000010,
        PH_ESC_COUNT  = 6'b000100,
        PH_ESC_COLOR  = 6'b001000,
        PH_PAIR_COLOR = 6'b010000,
        PH_DONE       = 6'b100000
    } phase_t;

    typedef enum logic [1:0] {
        LM_NONE    = 2'd0,
        LM_PIXEL   = 2'd1,
        LM_MULTI   = 2'd2,
        LM_UNKNOWN = 2'd3
    } line_mode_t;

    typedef struct packed {
        logic [DIM_BITS-1:0] sprite_width;
        logic [DIM_BITS-1:0] sprite_height;
        logic [7:0]          transparent_color;
    } cfg_t;

    typedef struct packed {
        logic [DIM_BITS-1:0] run_row;
        logic [DIM_BITS-1:0] run_column;
        logic [DIM_BITS-1:0] run_length;
        logic [7:0]          run_color;
        logic                sprite_done;
        logic [1:0]          decode_status;
    } run_t;

endpackage

`default_nettype wire

FILE: rtl/core/srld_if.sv
// Handshake interfaces for the byte stream and the run results.
`default_nettype none

interface srld_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] stream_byte;
    logic       first_byte;
    logic       last_byte;

    modport source (output valid, output stream_byte, output first_byte,
                    output last_byte, input ready);
    modport sink (input valid, input stream_byte, input first_byte,
                  input last_byte, output ready);
endinterface

interface srld_run_if;
    import srld_pkg::*;

    logic                valid;
    logic                ready;
    logic [DIM_BITS-1:0] run_row;
    logic [DIM_BITS-1:0] run_column;
    logic [DIM_BITS-1:0] run_length;
    logic [7:0]          run_color;
    logic                sprite_done;
    logic [1:0]          decode_status;

    modport source (output valid, output run_row, output run_column, output run_length,
                    output run_color, output sprite_done, output decode_status,
                    input ready);
    modport sink (input valid, input run_row, input run_column, input run_length,
                  input run_color, input sprite_done, input decode_status,
                  output ready);
endinterface

`default_nettype wire

FILE: rtl/core/srld_parser.sv
// Byte parser: holds the decode state and forms at most one clipped run per accepted item.
`default_nettype none

module srld_parser (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           accept,
    input  wire logic [7:0]     stream_byte,
    input  wire logic           first_byte,
    input  wire logic           last_byte,
    input  wire srld_pkg::cfg_t cfg,
    output srld_pkg::run_t      result,
    output logic                emit
);
    import srld_pkg::*;

    phase_t              phase_reg, phase_next, cur_phase;
    line_mode_t          mode_reg, mode_next, cur_mode;
    logic [7:0]          held_reg, held_next, cur_held;
    logic [DIM_BITS-1:0] col_reg, col_next, cur_col;
    logic [DIM_BITS-1:0] row_reg, row_next, cur_row;

    logic                empty;
    logic [DIM_BITS-1:0] avail;
    logic                do_fill;
    logic                do_put;
    logic [7:0]          put_count;
    logic [7:0]          put_color;
    logic [DIM_BITS-1:0] run_n;
    logic                done;
    logic [1:0]          status;

    always_comb
    begin
        cur_phase = first_byte ? PH_MODE : phase_reg;
        cur_mode  = first_byte ? LM_NONE : mode_reg;
        cur_held  = first_byte ? 8'd0 : held_reg;
        cur_col   = first_byte ? '0 : col_reg;
        cur_row   = first_byte ? '0 : row_reg;

        phase_next = cur_phase;
        mode_next  = cur_mode;
        held_next  = cur_held;
        col_next   = cur_col;
        row_next   = cur_row;

        empty = (cfg.sprite_width == '0) || (cfg.sprite_height == '0);
        avail = ((cur_row >= cfg.sprite_height) || (cur_col >= cfg.sprite_width)) ?
                '0 : cfg.sprite_width - cur_col;

        do_fill   = 1'b0;
        do_put    = 1'b0;
        put_count = 8'd0;
        put_color = 8'd0;
        run_n     = '0;
        done      = 1'b0;
        status    = ST_RUNNING;
        result    = '0;

        if (cur_phase != PH_DONE)
        begin
            if (empty)
            begin
                done   = 1'b1;
                status = ST_FINISHED;
            end
            else
            begin
                unique case (cur_phase)
                    PH_MODE:
                    begin
                        if (stream_byte == CODE_END)
                        begin
                            done   = 1'b1;
                            status = ST_FINISHED;
                        end
                        else if (stream_byte == CODE_FILL)
                        begin
                            do_fill = 1'b1;
                        end
                        else
                        begin
                            mode_next  = (stream_byte == CODE_PIXEL) ? LM_PIXEL :
                                         (stream_byte == CODE_MULTI) ? LM_MULTI : LM_UNKNOWN;
                            phase_next = PH_DATA;
                        end
                    end
                    PH_DATA:
                    begin
                        if (stream_byte == CODE_FILL)
                        begin
                            do_fill = 1'b1;
                        end
                        else if (cur_mode == LM_PIXEL)
                        begin
                            if (stream_byte == CODE_PIXEL)
                            begin
                                phase_next = PH_ESC_COUNT;
                            end
                            else
                            begin
                                do_put    = 1'b1;
                                put_count = 8'd1;
                                put_color = stream_byte;
                            end
                        end
                        else if (cur_mode == LM_MULTI)
                        begin
                            held_next  = stream_byte;
                            phase_next = PH_PAIR_COLOR;
                        end
                        else
                        begin
                            done   = 1'b1;
                            status = ST_BAD_MODE;
                        end
                    end
                    PH_ESC_COUNT:
                    begin
                        held_next  = stream_byte;
                        phase_next = PH_ESC_COLOR;
                    end
                    PH_ESC_COLOR, PH_PAIR_COLOR:
                    begin
                        do_put     = 1'b1;
                        put_count  = cur_held;
                        put_color  = stream_byte;
                        phase_next = PH_DATA;
                    end
                    default:
                    begin
                    end
                endcase

                if (do_fill)
                begin
                    run_n      = avail;
                    col_next   = '0;
                    row_next   = cur_row + 1'b1;
                    phase_next = PH_MODE;
                    result.run_color = cfg.transparent_color;
                    if (row_next >= cfg.sprite_height)
                    begin
                        done   = 1'b1;
                        status = ST_FINISHED;
                    end
                end
                else if (do_put)
                begin
                    run_n = (CNT_W'(put_count) < CNT_W'(avail)) ?
                            DIM_BITS'(put_count) : avail;
                    col_next = cur_col + run_n;
                    result.run_color = put_color;
                end

                if (do_fill || do_put)
                begin
                    result.run_row    = cur_row;
                    result.run_column = cur_col;
                    result.run_length = run_n;
                end

                if (!done && last_byte)
                begin
                    done   = 1'b1;
                    status = (phase_next == PH_MODE) ? ST_FINISHED : ST_EARLY_END;
                end
            end

            if (done)
            begin
                phase_next = PH_DONE;
            end
        end

        result.sprite_done   = done;
        result.decode_status = status;
        emit = (cur_phase != PH_DONE) && (done || (run_n != '0));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_MODE;
            mode_reg  <= LM_NONE;
            held_reg  <= 8'd0;
            col_reg   <= '0;
            row_reg   <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            mode_reg  <= mode_next;
            held_reg  <= held_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/sprite_rle_line_decoder.sv
// Top level of the sprite run-length line decoder with its register port.
//
// The stream channel takes one encoded byte per item, tagged first_byte and
// last_byte. Each accepted item updates the parser and gives zero or one run
// item on the runs channel: row, start column, clipped length and color, with
// sprite_done and decode_status on the item that ends the sprite.
// A run item goes into the output register, or into the skid register if
// that is held. One byte is accepted every cycle while the receiver keeps up.
// Results pass through an output register and a one-entry skid register; the
// stream side drops ready only while the skid register is full, so a stalled
// receiver holds the stream after at most one extra item that gives a run.
// Registers sprite_width (0x0), sprite_height (0x4) and transparent_color
// (0x8) are written over APB; the user must write them only while no sprite
// item is in flight, which the block does not enforce. Reset clears them, the
// parse state and both valid flags; the decoder then awaits a line mode byte.
`default_nettype none

module sprite_rle_line_decoder (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    srld_byte_if.sink                          stream,
    srld_run_if.source                         runs,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [srld_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [31:0]                   pwdata,
    output logic      [31:0]                   prdata,
    output logic                               pready
);
    import srld_pkg::*;

    cfg_t                 cfg_reg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 cfg_write;

    logic accept;
    logic emit;
    run_t result;

    logic out_valid_reg, out_valid_next;
    logic skid_valid_reg, skid_valid_next;
    run_t out_reg, out_next;
    run_t skid_reg, skid_next;
    logic take;

    assign pready    = 1'b1;
    assign reg_idx   = paddr[ADDR_LSB +: REG_IDX_W];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (reg_idx)
                REG_SPRITE_WIDTH:      cfg_reg.sprite_width <= pwdata[DIM_BITS-1:0];
                REG_SPRITE_HEIGHT:     cfg_reg.sprite_height <= pwdata[DIM_BITS-1:0];
                REG_TRANSPARENT_COLOR: cfg_reg.transparent_color <= pwdata[7:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (reg_idx)
            REG_SPRITE_WIDTH:      prdata = 32'(cfg_reg.sprite_width);
            REG_SPRITE_HEIGHT:     prdata = 32'(cfg_reg.sprite_height);
            REG_TRANSPARENT_COLOR: prdata = 32'(cfg_reg.transparent_color);
            default:               prdata = '0;
        endcase
    end

    assign stream.ready = !skid_valid_reg;
    assign accept       = stream.valid && !skid_valid_reg;

    srld_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .stream_byte (stream.stream_byte),
        .first_byte  (stream.first_byte),
        .last_byte   (stream.last_byte),
        .cfg         (cfg_reg),
        .result      (result),
        .emit        (emit)
    );

    assign take = out_valid_reg && runs.ready;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;

        if (!out_valid_reg || take)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else if (accept && emit)
            begin
                out_next       = result;
                out_valid_next = 1'b1;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
        else if (accept && emit)
        begin
            skid_next       = result;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign runs.valid         = out_valid_reg;
    assign runs.run_row       = out_reg.run_row;
    assign runs.run_column    = out_reg.run_column;
    assign runs.run_length    = out_reg.run_length;
    assign runs.run_color     = out_reg.run_color;
    assign runs.sprite_done   = out_reg.sprite_done;
    assign runs.decode_status = out_reg.decode_status;

endmodule

`default_nettype wire
